@@ design/ersv_pkg.sv @@
// package: constants, tables and register indexes of the exciter supply voltage block
package ersv_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int XW = 42;
  localparam int ZW = 34;
  localparam int LAT = CORDIC_STEPS + 78;

  localparam logic signed [ZW-1:0] HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI = 34'sd3373259426;
  localparam logic [29:0] INV_GAIN = 30'd652032874;
  localparam logic [15:0] FEX_K1 = 16'd28377;
  localparam logic [15:0] FEX_SLOPE1 = 16'd37814;
  localparam logic [15:0] FEX_K2 = 16'd49152;
  localparam logic [16:0] FEX_SLOPE3 = 17'd113508;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [31:0] FEX_CIRC = 32'd3221225472;
  localparam logic [30:0] VE_MAX = 31'h7FFFFFFF;

  typedef enum logic [2:0] {
    REG_POT_RE  = 3'd0,
    REG_POT_IM  = 3'd1,
    REG_CUR_RE  = 3'd2,
    REG_CUR_IM  = 3'd3,
    REG_KC      = 3'd4,
    REG_VB_LIM  = 3'd5
  } reg_idx_e;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd7;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ design/exciter_rectifier_supply_voltage.sv @@
// top level: pipelined rectifier supply voltage (Vb) of a static exciter
//
// channel   direction  handshake               payload
// config    in         cfg_we_i                cfg_idx_i, cfg_data_i
// item      in         start_i && !busy_o      volt_mag_i .. field_current_i
// result    out        valid_o (one cycle)     supply_volt_o .. source_zero_o
//
// one item per cycle; the pipeline runs through the cordic stages, two
// bit-per-stage square roots and a bit-per-stage divider; busy_o is
// always low
// rst_ni clears the registers and the valid line, payload flops are not reset
// results leave as one-cycle strobes, nothing is held back
module exciter_rectifier_supply_voltage
  import ersv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [30:0]        volt_mag_i,
  input  logic signed [18:0] volt_angle_i,
  input  logic signed [31:0] cur_real_i,
  input  logic signed [31:0] cur_imag_i,
  input  logic signed [31:0] field_current_i,
  output logic               valid_o,
  output logic signed [31:0] supply_volt_o,
  output logic [30:0]        source_volt_o,
  output logic               clamped_o,
  output logic               source_zero_o
);

  localparam int N = CORDIC_STEPS;
  localparam int PD = N + 39;

  typedef enum logic [2:0] {SEL_ONE, SEL_ZERO, SEL_LIN, SEL_CIRC, SEL_TAIL} sel_e;

  logic signed [31:0] pot_re_q, pot_im_q, cur_re_q, cur_im_q, kc_q, vb_lim_q;
  logic [LAT-1:0] vld_q;

  // input stage
  logic [30:0]          a_mag_q;
  logic signed [ZW-1:0] a_z_q;
  logic                 a_flip_q;
  logic signed [31:0]   a_ir_q, a_ii_q, a_ifd_q;
  logic signed [ZW-1:0] z_in;

  // cordic
  logic signed [XW-1:0] cx_q [N+1];
  logic signed [XW-1:0] cy_q [N+1];
  logic signed [ZW-1:0] cz_q [N+1];
  logic                 fl_q [N+1];
  logic signed [31:0]   ir_q [N+2];
  logic signed [31:0]   ii_q [N+2];
  logic signed [63:0]   pd_q [PD];
  logic [60:0]          x0_mul;

  // complex products
  logic signed [XW-1:0] xr, yr;
  logic signed [32:0]   vr_d, vi_d, vr_q, vi_q;
  logic signed [64:0]   m [8];
  logic signed [48:0]   pr_q [8];
  logic signed [50:0]   re_q, im_q;
  logic signed [50:0]   re_abs, im_abs;
  logic                 q_ovf_q;
  logic [61:0]          sq_re_q, sq_im_q;

  // magnitude square root
  logic [63:0] s1_rad_q [33];
  logic [34:0] s1_rem_q [33];
  logic [31:0] s1_root_q [33];
  logic        s1_ovf_q [33];
  logic [34:0] s1_remn [32];
  logic [34:0] s1_trial [32];

  logic [30:0] ve_q;
  logic        vz_q;

  // divider
  logic [47:0] dv_rem_q [17];
  logic [15:0] dv_quo_q [17];
  logic [30:0] dv_ve_q [17];
  logic        dv_zero_q [17];
  logic        dv_pos_q [17];
  logic        dv_big_q [17];
  logic [47:0] dv_dvs [16];

  // loading curve
  sel_e        f0_sel_q;
  logic [31:0] f0_lin1_q, f0_sq_q;
  logic [33:0] f0_lin3_q;
  logic [30:0] f0_ve_q;
  logic        f0_zero_q;
  logic [16:0] f1_a, f1_b;
  logic [31:0] s2_rad_q [17];
  logic [18:0] s2_rem_q [17];
  logic [15:0] s2_root_q [17];
  logic [16:0] s2_flin_q [17];
  logic        s2_circ_q [17];
  logic [30:0] s2_ve_q [17];
  logic        s2_zero_q [17];
  logic [18:0] s2_remn [16];
  logic [18:0] s2_trial [16];

  logic [16:0]        f2_f_q;
  logic [30:0]        f2_ve_q, m_ve_q;
  logic               f2_zero_q, m_zero_q;
  logic [47:0]        vb_full;
  logic signed [31:0] m_vb_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pot_re_q <= '0;
      pot_im_q <= '0;
      cur_re_q <= '0;
      cur_im_q <= '0;
      kc_q     <= '0;
      vb_lim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_POT_RE: pot_re_q <= cfg_data_i;
        REG_POT_IM: pot_im_q <= cfg_data_i;
        REG_CUR_RE: cur_re_q <= cfg_data_i;
        REG_CUR_IM: cur_im_q <= cfg_data_i;
        REG_KC:     kc_q     <= cfg_data_i;
        REG_VB_LIM: vb_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end

  assign z_in = ZW'(volt_angle_i) <<< 14;

  always_ff @(posedge clk_i) begin
    a_mag_q <= volt_mag_i;
    a_ir_q  <= cur_real_i;
    a_ii_q  <= cur_imag_i;
    a_ifd_q <= field_current_i;
    if (z_in > HALF_PI) begin
      a_z_q <= z_in - PI;
      a_flip_q <= 1'b1;
    end else if (z_in < -HALF_PI) begin
      a_z_q <= z_in + PI;
      a_flip_q <= 1'b1;
    end else begin
      a_z_q <= z_in;
      a_flip_q <= 1'b0;
    end
  end

  assign x0_mul = 61'(a_mag_q) * 61'(INV_GAIN);

  always_ff @(posedge clk_i) begin
    cx_q[0] <= XW'(x0_mul[60:22]);
    cy_q[0] <= '0;
    cz_q[0] <= a_z_q;
    fl_q[0] <= a_flip_q;
    ir_q[0] <= a_ir_q;
    ii_q[0] <= a_ii_q;
    pd_q[0] <= kc_q * a_ifd_q;
    for (int i = 0; i < N; i++) begin
      if (!cz_q[i][ZW-1]) begin
        cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] - atan_q30(i);
      end else begin
        cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] + atan_q30(i);
      end
      fl_q[i+1] <= fl_q[i];
    end
    for (int i = 1; i < N + 2; i++) begin
      ir_q[i] <= ir_q[i-1];
      ii_q[i] <= ii_q[i-1];
    end
    for (int i = 1; i < PD; i++) begin
      pd_q[i] <= pd_q[i-1];
    end
  end

  always_comb begin
    xr = (cx_q[N] + XW'(128)) >>> 8;
    yr = (cy_q[N] + XW'(128)) >>> 8;
    vr_d = fl_q[N] ? -xr[32:0] : xr[32:0];
    vi_d = fl_q[N] ? -yr[32:0] : yr[32:0];
    m[0] = pot_re_q * vr_q;
    m[1] = pot_im_q * vi_q;
    m[2] = cur_re_q * 33'(ir_q[N+1]);
    m[3] = cur_im_q * 33'(ii_q[N+1]);
    m[4] = pot_re_q * vi_q;
    m[5] = pot_im_q * vr_q;
    m[6] = cur_re_q * 33'(ii_q[N+1]);
    m[7] = cur_im_q * 33'(ir_q[N+1]);
    re_abs = re_q[50] ? -re_q : re_q;
    im_abs = im_q[50] ? -im_q : im_q;
  end

  always_ff @(posedge clk_i) begin
    vr_q <= vr_d;
    vi_q <= vi_d;
    for (int k = 0; k < 8; k++) begin
      pr_q[k] <= m[k][64:16];
    end
    re_q <= pr_q[0] - pr_q[1] + pr_q[2] - pr_q[3];
    im_q <= pr_q[4] + pr_q[5] + pr_q[6] + pr_q[7];
    q_ovf_q <= (re_q >= 51'sd2147483648) || (re_q <= -51'sd2147483648) ||
               (im_q >= 51'sd2147483648) || (im_q <= -51'sd2147483648);
    sq_re_q <= 62'(re_abs[30:0]) * 62'(re_abs[30:0]);
    sq_im_q <= 62'(im_abs[30:0]) * 62'(im_abs[30:0]);
  end

  always_comb begin
    for (int k = 0; k < 32; k++) begin
      s1_remn[k]  = {s1_rem_q[k][32:0], s1_rad_q[k][63:62]};
      s1_trial[k] = {1'b0, s1_root_q[k], 2'b01};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_rad_q[0]  <= 64'(sq_re_q) + 64'(sq_im_q);
    s1_rem_q[0]  <= '0;
    s1_root_q[0] <= '0;
    s1_ovf_q[0]  <= q_ovf_q;
    for (int k = 0; k < 32; k++) begin
      s1_rad_q[k+1] <= s1_rad_q[k] << 2;
      s1_ovf_q[k+1] <= s1_ovf_q[k];
      if (s1_remn[k] >= s1_trial[k]) begin
        s1_rem_q[k+1]  <= s1_remn[k] - s1_trial[k];
        s1_root_q[k+1] <= {s1_root_q[k][30:0], 1'b1};
      end else begin
        s1_rem_q[k+1]  <= s1_remn[k];
        s1_root_q[k+1] <= {s1_root_q[k][30:0], 1'b0};
      end
    end
    if (s1_ovf_q[32] || s1_root_q[32][31]) begin
      ve_q <= VE_MAX;
      vz_q <= 1'b0;
    end else begin
      ve_q <= s1_root_q[32][30:0];
      vz_q <= (s1_root_q[32][30:0] == '0);
    end
  end

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      dv_dvs[j] = 48'(dv_ve_q[j]) << (15 - j);
    end
  end

  always_ff @(posedge clk_i) begin
    dv_rem_q[0]  <= pd_q[PD-1][47:0];
    dv_quo_q[0]  <= '0;
    dv_ve_q[0]   <= ve_q;
    dv_zero_q[0] <= vz_q;
    dv_pos_q[0]  <= (pd_q[PD-1] > 64'sd0);
    dv_big_q[0]  <= (pd_q[PD-1] >= $signed({17'b0, ve_q, 16'b0}));
    for (int j = 0; j < 16; j++) begin
      dv_ve_q[j+1]   <= dv_ve_q[j];
      dv_zero_q[j+1] <= dv_zero_q[j];
      dv_pos_q[j+1]  <= dv_pos_q[j];
      dv_big_q[j+1]  <= dv_big_q[j];
      if (dv_rem_q[j] >= dv_dvs[j]) begin
        dv_rem_q[j+1] <= dv_rem_q[j] - dv_dvs[j];
        dv_quo_q[j+1] <= {dv_quo_q[j][14:0], 1'b1};
      end else begin
        dv_rem_q[j+1] <= dv_rem_q[j];
        dv_quo_q[j+1] <= {dv_quo_q[j][14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!dv_pos_q[16]) begin
      f0_sel_q <= SEL_ONE;
    end else if (dv_big_q[16]) begin
      f0_sel_q <= SEL_ZERO;
    end else if (dv_quo_q[16] <= FEX_K1) begin
      f0_sel_q <= SEL_LIN;
    end else if (dv_quo_q[16] <= FEX_K2) begin
      f0_sel_q <= SEL_CIRC;
    end else begin
      f0_sel_q <= SEL_TAIL;
    end
    f0_lin1_q <= 32'(dv_quo_q[16]) * 32'(FEX_SLOPE1);
    f0_lin3_q <= 34'(FEX_SLOPE3) * 34'(ONE_Q16 - 17'(dv_quo_q[16]));
    f0_sq_q   <= 32'(dv_quo_q[16]) * 32'(dv_quo_q[16]);
    f0_ve_q   <= dv_ve_q[16];
    f0_zero_q <= dv_zero_q[16];
  end

  assign f1_a = ONE_Q16 - 17'((33'(f0_lin1_q) + 33'd32768) >> 16);
  assign f1_b = 17'((35'(f0_lin3_q) + 35'd32768) >> 16);

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      s2_remn[k]  = {s2_rem_q[k][16:0], s2_rad_q[k][31:30]};
      s2_trial[k] = {1'b0, s2_root_q[k], 2'b01};
    end
  end

  always_ff @(posedge clk_i) begin
    case (f0_sel_q)
      SEL_ONE:  s2_flin_q[0] <= ONE_Q16;
      SEL_LIN:  s2_flin_q[0] <= f1_a;
      SEL_TAIL: s2_flin_q[0] <= f1_b;
      default:  s2_flin_q[0] <= '0;
    endcase
    s2_circ_q[0] <= (f0_sel_q == SEL_CIRC);
    s2_rad_q[0]  <= FEX_CIRC - f0_sq_q;
    s2_rem_q[0]  <= '0;
    s2_root_q[0] <= '0;
    s2_ve_q[0]   <= f0_ve_q;
    s2_zero_q[0] <= f0_zero_q;
    for (int k = 0; k < 16; k++) begin
      s2_rad_q[k+1]  <= s2_rad_q[k] << 2;
      s2_flin_q[k+1] <= s2_flin_q[k];
      s2_circ_q[k+1] <= s2_circ_q[k];
      s2_ve_q[k+1]   <= s2_ve_q[k];
      s2_zero_q[k+1] <= s2_zero_q[k];
      if (s2_remn[k] >= s2_trial[k]) begin
        s2_rem_q[k+1]  <= s2_remn[k] - s2_trial[k];
        s2_root_q[k+1] <= {s2_root_q[k][14:0], 1'b1};
      end else begin
        s2_rem_q[k+1]  <= s2_remn[k];
        s2_root_q[k+1] <= {s2_root_q[k][14:0], 1'b0};
      end
    end
    f2_f_q    <= s2_circ_q[16] ? 17'(s2_root_q[16]) : s2_flin_q[16];
    f2_ve_q   <= s2_ve_q[16];
    f2_zero_q <= s2_zero_q[16];
  end

  assign vb_full = 48'(f2_ve_q) * 48'(f2_f_q) + 48'd32768;

  always_ff @(posedge clk_i) begin
    m_vb_q   <= vb_full[47:16];
    m_ve_q   <= f2_ve_q;
    m_zero_q <= f2_zero_q;
    source_volt_o <= m_ve_q;
    if (m_zero_q) begin
      supply_volt_o <= '0;
      clamped_o     <= 1'b0;
      source_zero_o <= 1'b1;
    end else if (m_vb_q > vb_lim_q) begin
      supply_volt_o <= vb_lim_q;
      clamped_o     <= 1'b1;
      source_zero_o <= 1'b0;
    end else begin
      supply_volt_o <= m_vb_q;
      clamped_o     <= 1'b0;
      source_zero_o <= 1'b0;
    end
  end

  assign valid_o = vld_q[LAT-1];

`ifndef SYNTHESIS
  a_zero_no_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(clamped_o && source_zero_o))
    else $error("clamp flagged on zero source item");
  a_zero_vb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && source_zero_o |-> supply_volt_o == '0 && source_volt_o == '0)
    else $error("zero source item carries nonzero voltage");
  a_nonzero_ve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !source_zero_o |-> source_volt_o != '0)
    else $error("zero source voltage not flagged");
  a_valid_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> vld_q[0])
    else $error("accepted item lost at entry");
`endif

endmodule
